// File: sv/bsp_pkg.sv
// Shared types, codes and constants of the stroke painter.
`default_nettype none

package bsp_pkg;

   // Grid geometry. Cell coordinates are fixed at six bits.
   localparam int COORD_W  = 6;
   localparam int GRID_DIM = 64;
   localparam logic [COORD_W:0] GRID_LIMIT = (COORD_W + 1)'(GRID_DIM);

   // Bresenham error term and its doubled form.
   localparam int ERR_W = 8;

   // Event kinds.
   typedef enum logic [1:0] {
      MODE_PRESS   = 2'd0,
      MODE_MOVE    = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   // Buttons.
   localparam logic BTN_LEFT  = 1'b0;
   localparam logic BTN_RIGHT = 1'b1;

   // Cell values.
   localparam logic CELL_ALIVE = 1'b1;
   localparam logic CELL_DEAD  = 1'b0;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;   // accept the input item and set up the walk
      logic step;   // emit the current point and advance the walker
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic draw;      // the offered item causes cell writes
      logic done;      // the walker stands on the target cell
      logic out_free;  // the output register can take a new item
   } sts_type;

endpackage

`default_nettype wire

// File: sv/bsp_req_if.sv
// Input channel carrying stroke events.
`default_nettype none

interface bsp_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  mode;
   logic                        button;
   logic                        active_held;
   logic                        on_cell;
   logic [bsp_pkg::COORD_W-1:0] cell_row;
   logic [bsp_pkg::COORD_W-1:0] cell_col;

   modport source (
      output valid, mode, button, active_held, on_cell, cell_row, cell_col,
      input  ready
   );
   modport sink (
      input  valid, mode, button, active_held, on_cell, cell_row, cell_col,
      output ready
   );
endinterface

`default_nettype wire

// File: sv/bsp_rsp_if.sv
// Result channel carrying cell writes.
`default_nettype none

interface bsp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bsp_pkg::COORD_W-1:0] write_row;
   logic [bsp_pkg::COORD_W-1:0] write_col;
   logic                        write_value;
   logic                        last_point;

   modport source (
      output valid, write_row, write_col, write_value, last_point,
      input  ready
   );
   modport sink (
      input  valid, write_row, write_col, write_value, last_point,
      output ready
   );
endinterface

`default_nettype wire

// File: sv/bsp_ctrl.sv
// Controller state machine of the stroke painter.
`default_nettype none

module bsp_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bsp_pkg::sts_type sts,
   output bsp_pkg::cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Items are taken only between walks; a walk emits one point per free slot.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      cmd.take  = (state_ff == ST_IDLE) && req_valid;
      cmd.step  = (state_ff == ST_WALK) && sts.out_free;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.take && sts.draw) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (cmd.step && sts.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/bsp_datapath.sv
// Datapath of the stroke painter: stroke state, line walker and output register.
`default_nettype none

module bsp_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bsp_pkg::cmd_type            cmd,
   output bsp_pkg::sts_type                 sts,
   input  wire logic [1:0]                  req_mode,
   input  wire logic                        req_button,
   input  wire logic                        req_active_held,
   input  wire logic                        req_on_cell,
   input  wire logic [bsp_pkg::COORD_W-1:0] req_cell_row,
   input  wire logic [bsp_pkg::COORD_W-1:0] req_cell_col,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [bsp_pkg::COORD_W-1:0]      rsp_write_row,
   output logic [bsp_pkg::COORD_W-1:0]      rsp_write_col,
   output logic                             rsp_write_value,
   output logic                             rsp_last_point
);

   localparam int CW = bsp_pkg::COORD_W;
   localparam int EW = bsp_pkg::ERR_W;

   // Stroke state.
   logic stroke_ff, stroke_in;
   logic paint_ff, paint_in;
   logic anchor_valid_ff, anchor_valid_in;
   logic [CW-1:0] anchor_row_ff, anchor_row_in;
   logic [CW-1:0] anchor_col_ff, anchor_col_in;

   // Line walker.
   logic [CW-1:0] walk_row_ff, walk_row_in;
   logic [CW-1:0] walk_col_ff, walk_col_in;
   logic [CW-1:0] target_row_ff, target_row_in;
   logic [CW-1:0] target_col_ff, target_col_in;
   logic signed [EW-1:0] line_error_ff, line_error_in;
   logic signed [EW-1:0] delta_x_ff, delta_x_in;
   logic signed [EW-1:0] delta_y_ff, delta_y_in;
   logic step_x_ff, step_x_in;
   logic step_y_ff, step_y_in;

   // Output register.
   logic rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] out_row_ff, out_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic out_value_ff, out_value_in;
   logic out_last_ff, out_last_in;

   // Decode of the offered item.
   logic is_press, is_move, is_release;
   logic hit;
   logic release_match;
   logic from_anchor;
   logic [CW:0] diff_row, diff_col;
   logic [CW:0] abs_row, abs_col;

   // Walker step terms.
   logic signed [EW:0] err_twice;
   logic move_x, move_y;
   logic signed [EW-1:0] add_x, add_y;

   always_comb begin
      is_press   = (req_mode == bsp_pkg::MODE_PRESS);
      is_move    = (req_mode == bsp_pkg::MODE_MOVE);
      is_release = (req_mode == bsp_pkg::MODE_RELEASE);
      // A cell beyond the grid counts as a miss.
      hit = req_on_cell
         && ({1'b0, req_cell_row} < bsp_pkg::GRID_LIMIT)
         && ({1'b0, req_cell_col} < bsp_pkg::GRID_LIMIT);
      release_match = ((req_button == bsp_pkg::BTN_LEFT) && (paint_ff == bsp_pkg::CELL_ALIVE))
         || ((req_button == bsp_pkg::BTN_RIGHT) && (paint_ff == bsp_pkg::CELL_DEAD));
      // A press always forgets the anchor, so only a move walks from it.
      from_anchor = is_move && anchor_valid_ff;
      diff_row = {1'b0, req_cell_row} - {1'b0, anchor_row_ff};
      diff_col = {1'b0, req_cell_col} - {1'b0, anchor_col_ff};
      abs_row  = diff_row[CW] ? ((CW + 1)'(0) - diff_row) : diff_row;
      abs_col  = diff_col[CW] ? ((CW + 1)'(0) - diff_col) : diff_col;
   end

   // Bresenham step decision on the current error term.
   always_comb begin
      err_twice = $signed({line_error_ff, 1'b0});
      move_x = (err_twice >= $signed({delta_y_ff[EW-1], delta_y_ff}));
      move_y = (err_twice <= $signed({delta_x_ff[EW-1], delta_x_ff}));
      add_x  = move_x ? delta_y_ff : EW'(0);
      add_y  = move_y ? delta_x_ff : EW'(0);
   end

   // Status to the controller.
   always_comb begin
      sts.draw = hit && (is_press || (is_move && stroke_ff && req_active_held));
      sts.done = (walk_row_ff == target_row_ff) && (walk_col_ff == target_col_ff);
      sts.out_free = !rsp_valid_ff || rsp_ready;
   end

   // Next values of all registers.
   always_comb begin
      stroke_in       = stroke_ff;
      paint_in        = paint_ff;
      anchor_valid_in = anchor_valid_ff;
      anchor_row_in   = anchor_row_ff;
      anchor_col_in   = anchor_col_ff;
      walk_row_in     = walk_row_ff;
      walk_col_in     = walk_col_ff;
      target_row_in   = target_row_ff;
      target_col_in   = target_col_ff;
      line_error_in   = line_error_ff;
      delta_x_in      = delta_x_ff;
      delta_y_in      = delta_y_ff;
      step_x_in       = step_x_ff;
      step_y_in       = step_y_ff;
      rsp_valid_in    = rsp_valid_ff;
      out_row_in      = out_row_ff;
      out_col_in      = out_col_ff;
      out_value_in    = out_value_ff;
      out_last_in     = out_last_ff;

      // Stroke bookkeeping and walk setup when an item is taken.
      if (cmd.take) begin
         if (is_press) begin
            stroke_in       = 1'b1;
            paint_in        = (req_button == bsp_pkg::BTN_LEFT) ?
                              bsp_pkg::CELL_ALIVE : bsp_pkg::CELL_DEAD;
            anchor_valid_in = 1'b0;
         end else if (is_release && release_match) begin
            stroke_in       = 1'b0;
            paint_in        = bsp_pkg::CELL_ALIVE;
            anchor_valid_in = 1'b0;
         end
         if (sts.draw) begin
            anchor_valid_in = 1'b1;
            anchor_row_in   = req_cell_row;
            anchor_col_in   = req_cell_col;
            target_row_in   = req_cell_row;
            target_col_in   = req_cell_col;
            walk_row_in     = from_anchor ? anchor_row_ff : req_cell_row;
            walk_col_in     = from_anchor ? anchor_col_ff : req_cell_col;
            delta_x_in      = EW'(abs_col);
            delta_y_in      = EW'(0) - EW'(abs_row);
            line_error_in   = EW'(abs_col) - EW'(abs_row);
            step_x_in       = (anchor_col_ff < req_cell_col);
            step_y_in       = (anchor_row_ff < req_cell_row);
         end
      end

      // Emit the current point, then move the walker unless it has arrived.
      if (cmd.step) begin
         rsp_valid_in = 1'b1;
         out_row_in   = walk_row_ff;
         out_col_in   = walk_col_ff;
         out_value_in = paint_ff;
         out_last_in  = sts.done;
         if (!sts.done) begin
            line_error_in = line_error_ff + add_x + add_y;
            if (move_x) begin
               walk_col_in = step_x_ff ? (walk_col_ff + CW'(1)) : (walk_col_ff - CW'(1));
            end
            if (move_y) begin
               walk_row_in = step_y_ff ? (walk_row_ff + CW'(1)) : (walk_row_ff - CW'(1));
            end
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stroke_ff       <= 1'b0;
         paint_ff        <= bsp_pkg::CELL_ALIVE;
         anchor_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         anchor_row_ff   <= '0;
         anchor_col_ff   <= '0;
         walk_row_ff     <= '0;
         walk_col_ff     <= '0;
         target_row_ff   <= '0;
         target_col_ff   <= '0;
         line_error_ff   <= '0;
      end else begin
         stroke_ff       <= stroke_in;
         paint_ff        <= paint_in;
         anchor_valid_ff <= anchor_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         anchor_row_ff   <= anchor_row_in;
         anchor_col_ff   <= anchor_col_in;
         walk_row_ff     <= walk_row_in;
         walk_col_ff     <= walk_col_in;
         target_row_ff   <= target_row_in;
         target_col_ff   <= target_col_in;
         line_error_ff   <= line_error_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_x_ff    <= delta_x_in;
      delta_y_ff    <= delta_y_in;
      step_x_ff     <= step_x_in;
      step_y_ff     <= step_y_in;
      out_row_ff    <= out_row_in;
      out_col_ff    <= out_col_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_write_row   = out_row_ff;
   assign rsp_write_col   = out_col_ff;
   assign rsp_write_value = out_value_ff;
   assign rsp_last_point  = out_last_ff;

endmodule

`default_nettype wire

// File: sv/bresenham_stroke_painter_unit.sv
// Top level of the stroke painter: controller, datapath and channel hookup.
`default_nettype none

// The unit turns pointer events on a 64 x 64 cell grid into cell writes. A
// press starts a stroke and writes the hit cell; a move with the stroke's
// button held walks a Bresenham line from the last painted cell to the hit
// cell and sends one write item per point, flagging the final one; a release
// of the active button ends the stroke. Events that miss the grid send
// nothing. An event that draws keeps the input closed while the line walker
// emits one cell write per cycle whenever the result channel can take one,
// so a move sends max(|d_row|, |d_col|) + 1 writes (up to 64). The output
// register lets the next event be accepted while the final write of a line
// waits to be taken; a stalled result channel pauses the walker.
module bresenham_stroke_painter_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   bsp_req_if.sink    req_chan,
   bsp_rsp_if.source  rsp_chan
);

   bsp_pkg::cmd_type cmd;
   bsp_pkg::sts_type sts;
   logic             ctrl_ready;

   // Sequencing of items and walk steps.
   bsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctrl_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_chan.ready = ctrl_ready;

   // Stroke state, line walker and output register.
   bsp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_mode        (req_chan.mode),
      .req_button      (req_chan.button),
      .req_active_held (req_chan.active_held),
      .req_on_cell     (req_chan.on_cell),
      .req_cell_row    (req_chan.cell_row),
      .req_cell_col    (req_chan.cell_col),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_write_row   (rsp_chan.write_row),
      .rsp_write_col   (rsp_chan.write_col),
      .rsp_write_value (rsp_chan.write_value),
      .rsp_last_point  (rsp_chan.last_point)
   );

endmodule

`default_nettype wire
